// ===== rtl/rlp_pkg.sv =====
package rlp_pkg;

  localparam int ADDR_MAX   = 255;
  localparam int ADDR_LEN_W = $clog2(ADDR_MAX + 1);

  localparam int MAG_W = 32;
  localparam int ACC_W = MAG_W + 3;
  localparam logic [MAG_W-1:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [MAG_W-1:0] POS_MAX   = 32'h7FFF_FFFF;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_R     = 8'h52;

  localparam logic KIND_ADDR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [2:0] KEYWORD_LEN = 3'd6;

  typedef enum logic [1:0] {
    REQ_GET = 2'd0,
    REQ_INF = 2'd1,
    REQ_BAD = 2'd2
  } req_type_t;

  typedef enum logic [3:0] {
    NP_LEAD   = 4'b0001,
    NP_SIGN   = 4'b0010,
    NP_DIGITS = 4'b0100,
    NP_STOP   = 4'b1000
  } num_phase_t;

  typedef enum logic [4:0] {
    RP_SEEK  = 5'b00001,
    RP_START = 5'b00010,
    RP_DASH  = 5'b00100,
    RP_END   = 5'b01000,
    RP_DONE  = 5'b10000
  } range_phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       final_byte;
  } rlp_in_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         addr_byte;
    req_type_t          req_type;
    logic               addr_truncated;
    logic               range_found;
    logic [30:0]        range_start;
    logic signed [31:0] range_end;
    logic               end_open;
    logic               number_saturated;
  } rlp_out_t;

  typedef struct packed {
    logic [MAG_W-1:0] value;
    logic             sat;
  } num_val_t;

  typedef struct packed {
    logic      emit;
    req_type_t req_type;
    logic      truncated;
  } addr_res_t;

  typedef struct packed {
    logic               found;
    logic [30:0]        start_val;
    logic signed [31:0] end_val;
    logic               end_open;
    logic               saturated;
  } range_sum_t;

  function automatic logic [7:0] get_char(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0:    ch = 8'h47;
      2'd1:    ch = 8'h45;
      default: ch = 8'h54;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] inf_char(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0:    ch = 8'h49;
      2'd1:    ch = 8'h4E;
      default: ch = 8'h46;
    endcase
    return ch;
  endfunction

  // "Range " keyword, position wraps to the first letter past the end
  function automatic logic [7:0] range_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd1:    ch = 8'h61;
      3'd2:    ch = 8'h6E;
      3'd3:    ch = 8'h67;
      3'd4:    ch = 8'h65;
      3'd5:    ch = CH_SPACE;
      default: ch = CH_R;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/request_line_parser_unit.sv =====
// request line parser
// input channel in_valid / in_ready / in_data carries one request byte per
// transaction, with final_byte set on the last byte of a request.
// output channel out_valid / out_ready / out_data carries results: an address
// byte item (kind 0) for each of the first 255 address characters of a GET or
// INF request, and one summary item (kind 1) on the final byte with class,
// truncation flag and the parsed Range start and end values.
// a result is registered and shows on out_valid in the cycle after its byte is taken.
// throughput: one byte per cycle while the output is not stalled; each byte
// runs through the class/address tracker and the Range scanner with its two
// decimal accumulators combinationally and lands in the output register.
// a byte produces at most one result; bytes that produce none are absorbed.
// when out_ready is low with a result held, in_ready drops until the result
// is taken, so nothing is lost or repeated.
// reset clears all parse state and out_valid; after a final byte the block
// returns to the same cleared state for the next request.
module request_line_parser_unit import rlp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  rlp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rlp_out_t out_data
);

  logic       take;
  logic       res_valid;
  rlp_out_t   res;
  addr_res_t  addr_res;
  range_sum_t range_res;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  rlp_addr_tracker u_addr (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_item (in_data),
    .res     (addr_res)
  );

  rlp_range_scanner u_range (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_item (in_data),
    .sum     (range_res)
  );

  always_comb begin
    res          = '0;
    res.req_type = addr_res.req_type;
    res_valid    = in_data.final_byte || addr_res.emit;
    if (in_data.final_byte) begin
      res.kind             = KIND_SUMMARY;
      res.addr_truncated   = addr_res.truncated;
      res.range_found      = range_res.found;
      res.range_start      = range_res.start_val;
      res.range_end        = range_res.end_val;
      res.end_open         = range_res.end_open;
      res.number_saturated = range_res.saturated;
    end else begin
      res.kind      = KIND_ADDR;
      res.addr_byte = in_data.byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= res;
    end
  end

endmodule

// ===== rtl/rlp_num_acc.sv =====
module rlp_num_acc import rlp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       feed,
  input  logic       clear,
  input  logic [7:0] ch,
  output num_val_t   val
);

  num_phase_t       phase, phase_next;
  logic [MAG_W-1:0] mag, mag_next;
  logic             neg, neg_next;
  logic             over, over_next;

  logic             dig, space;
  logic [ACC_W-1:0] acc;

  always_comb begin
    dig   = (ch >= CH_ZERO) && (ch <= CH_NINE);
    space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    // mag * 10 + digit
    acc = ({{(ACC_W-MAG_W){1'b0}}, mag} << 3) + ({{(ACC_W-MAG_W){1'b0}}, mag} << 1)
        + ACC_W'(ch[3:0]);

    phase_next = phase;
    mag_next   = mag;
    neg_next   = neg;
    over_next  = over;

    if (feed) begin
      unique case (phase)
        NP_LEAD: begin
          if (!dig) begin
            if (!space) begin
              if ((ch == CH_PLUS) || (ch == CH_DASH)) begin
                neg_next   = (ch == CH_DASH);
                phase_next = NP_SIGN;
              end else begin
                phase_next = NP_STOP;
              end
            end
          end else begin
            phase_next = NP_DIGITS;
            if (acc > ACC_W'(MAG_LIMIT)) begin
              mag_next  = MAG_LIMIT;
              over_next = 1'b1;
            end else begin
              mag_next = acc[MAG_W-1:0];
            end
          end
        end
        NP_SIGN, NP_DIGITS: begin
          if (!dig) begin
            phase_next = NP_STOP;
          end else begin
            phase_next = NP_DIGITS;
            if (acc > ACC_W'(MAG_LIMIT)) begin
              mag_next  = MAG_LIMIT;
              over_next = 1'b1;
            end else begin
              mag_next = acc[MAG_W-1:0];
            end
          end
        end
        NP_STOP: begin
        end
        default: begin
          phase_next = NP_STOP;
        end
      endcase
    end

    // clamp to the signed 32-bit range
    if (neg_next) begin
      val.value = over_next ? MAG_LIMIT : (MAG_W'(0) - mag_next);
      val.sat   = over_next;
    end else begin
      val.value = mag_next[MAG_W-1] ? POS_MAX : mag_next;
      val.sat   = mag_next[MAG_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      phase <= NP_LEAD;
      mag   <= '0;
      neg   <= 1'b0;
      over  <= 1'b0;
    end else begin
      phase <= phase_next;
      mag   <= mag_next;
      neg   <= neg_next;
      over  <= over_next;
    end
  end

endmodule

// ===== rtl/rlp_addr_tracker.sv =====
module rlp_addr_tracker import rlp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  rlp_in_t   in_item,
  output addr_res_t res
);

  logic [2:0]            cp;
  logic                  get_m, inf_m;
  logic                  done;
  logic [ADDR_LEN_W-1:0] len;
  logic                  ovf;

  logic                  in_word, get_upd, inf_upd;
  logic                  addr_slot, room, is_nl, fin;
  logic [7:0]            c;
  req_type_t             typ;

  always_comb begin
    c       = in_item.byte_value;
    fin     = in_item.final_byte;
    is_nl   = (c == CH_NL);
    in_word = (cp < 3'd3);
    get_upd = get_m && (!in_word || (c == get_char(cp[1:0])));
    inf_upd = inf_m && (!in_word || (c == inf_char(cp[1:0])));

    // class is known once three bytes are in
    if ((cp >= 3'd2) && ((cp >= 3'd3) || fin)) begin
      typ = get_upd ? REQ_GET : (inf_upd ? REQ_INF : REQ_BAD);
    end else begin
      typ = REQ_BAD;
    end

    addr_slot = (cp >= 3'd4) && !done && (typ != REQ_BAD);
    room      = (len < ADDR_LEN_W'(ADDR_MAX));

    res.emit      = addr_slot && !is_nl && !fin && room;
    res.req_type  = typ;
    // the final byte never adds to the overflow
    res.truncated = ovf;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && fin)) begin
      cp    <= '0;
      get_m <= 1'b1;
      inf_m <= 1'b1;
      done  <= 1'b0;
      len   <= '0;
      ovf   <= 1'b0;
    end else if (take) begin
      if (cp < 3'd5) begin
        cp <= cp + 3'd1;
      end
      get_m <= get_upd;
      inf_m <= inf_upd;
      if (addr_slot) begin
        if (is_nl) begin
          done <= 1'b1;
        end else if (room) begin
          len <= len + ADDR_LEN_W'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/rlp_range_scanner.sv =====
module rlp_range_scanner import rlp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  rlp_in_t    in_item,
  output range_sum_t sum
);

  range_phase_t phase, phase_next;
  logic [2:0]   kp, kp_next;
  logic         eopen, eopen_next;
  logic         feed_s, feed_e, found, fin;
  logic [7:0]   c;
  num_val_t     start_val, end_val;

  always_comb begin
    c          = in_item.byte_value;
    fin        = in_item.final_byte;
    phase_next = phase;
    kp_next    = kp;
    eopen_next = eopen;
    feed_s     = 1'b0;
    feed_e     = 1'b0;

    unique case (phase)
      RP_SEEK: begin
        if (c == range_char(kp)) begin
          kp_next = kp + 3'd1;
        end else begin
          kp_next = (c == CH_R) ? 3'd1 : 3'd0;
        end
        if (kp_next >= KEYWORD_LEN) begin
          phase_next = RP_START;
        end
      end
      RP_DASH: begin
        // byte right after a dash, unless a newline, goes to the end text as is
        if (c == CH_NL) begin
          eopen_next = 1'b1;
          phase_next = RP_DONE;
        end else begin
          feed_e     = 1'b1;
          phase_next = RP_END;
        end
      end
      RP_START, RP_END: begin
        if (c == CH_NL) begin
          phase_next = RP_DONE;
        end else if (c == CH_DASH) begin
          phase_next = RP_DASH;
        end else begin
          feed_s = (phase == RP_START);
          feed_e = (phase == RP_END);
        end
      end
      RP_DONE: begin
      end
      default: begin
        phase_next = RP_DONE;
      end
    endcase

    found         = (phase_next != RP_SEEK);
    sum.found     = found;
    sum.end_open  = eopen_next;
    sum.start_val = found ? start_val.value[30:0] : 31'd0;
    if (!found) begin
      sum.end_val = '0;
    end else if (eopen_next) begin
      sum.end_val = -32'sd1;
    end else begin
      sum.end_val = end_val.value;
    end
    sum.saturated = found && (start_val.sat || (!eopen_next && end_val.sat));
  end

  rlp_num_acc u_start (
    .clk   (clk),
    .rst   (rst),
    .feed  (take && feed_s),
    .clear (take && fin),
    .ch    (c),
    .val   (start_val)
  );

  rlp_num_acc u_end (
    .clk   (clk),
    .rst   (rst),
    .feed  (take && feed_e),
    .clear (take && fin),
    .ch    (c),
    .val   (end_val)
  );

  always_ff @(posedge clk) begin
    if (rst || (take && fin)) begin
      phase <= RP_SEEK;
      kp    <= '0;
      eopen <= 1'b0;
    end else if (take) begin
      phase <= phase_next;
      kp    <= kp_next;
      eopen <= eopen_next;
    end
  end

endmodule

// ===== rtl/rlp_checker.sv =====
module rlp_checker import rlp_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_ready,
  input rlp_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input rlp_out_t out_data
);

  // a held result keeps its value while the receiver stalls
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // address bytes only come from a valid request
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind == KIND_ADDR) |-> (out_data.req_type != REQ_BAD))
    else $error("address byte for an invalid request");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind == KIND_SUMMARY) && !out_data.range_found |->
      (out_data.range_start == 31'd0) && (out_data.range_end == 32'sd0) &&
      !out_data.end_open && !out_data.number_saturated)
    else $error("range values reported without a Range keyword");

  // a final byte always yields a summary on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.final_byte |=>
      out_valid && (out_data.kind == KIND_SUMMARY))
    else $error("final byte without a summary transaction");

endmodule

bind request_line_parser_unit rlp_checker u_rlp_checker (.*);

// ===== verif/rlp_result_checker.sv =====
`timescale 1ns / 100ps

module rlp_result_checker import rlp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_ready,
  input  rlp_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  rlp_out_t out_data,
  output int       mismatches,
  output int       pending
);

  localparam logic [23:0] GET_WORD   = "GET";
  localparam logic [23:0] INF_WORD   = "INF";
  localparam logic [47:0] RANGE_WORD = "Range ";
  localparam int          PRINT_MAX  = 50;

  typedef struct packed {
    logic [31:0] mag;
    num_phase_t  phase;
    logic        neg;
    logic        over;
  } number_acc_t;

  localparam number_acc_t NUMBER_CLEAR = '{mag: '0, phase: NP_LEAD, neg: 1'b0, over: 1'b0};

  // parse state of the request in flight
  logic [2:0]   char_pos;
  logic         get_ok;
  logic         inf_ok;
  logic         addr_done;
  int           addr_len;
  logic         addr_over;
  logic [2:0]   kw_pos;
  range_phase_t rng_phase;
  number_acc_t  start_num;
  number_acc_t  end_num;
  logic         end_open;

  rlp_out_t awaited_results[$];
  int       mismatch_count = 0;
  int       pending_count  = 0;

  assign mismatches = mismatch_count;
  assign pending    = pending_count;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_MAX) begin
      $display("%0t rlp_result_checker: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
    end
  endtask

  task automatic clear_parse_state();
    char_pos  = '0;
    get_ok    = 1'b1;
    inf_ok    = 1'b1;
    addr_done = 1'b0;
    addr_len  = 0;
    addr_over = 1'b0;
    kw_pos    = '0;
    rng_phase = RP_SEEK;
    start_num = NUMBER_CLEAR;
    end_num   = NUMBER_CLEAR;
    end_open  = 1'b0;
  endtask

  // one atoi step: leading blanks, optional sign, digits, then stop
  function automatic number_acc_t feed_number(input number_acc_t n, input logic [7:0] c);
    logic        is_digit;
    logic        is_blank;
    logic [35:0] grown;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    if (n.phase == NP_STOP) begin
      return n;
    end
    if (n.phase == NP_LEAD && !is_digit) begin
      if (c == CH_PLUS || c == CH_DASH) begin
        n.neg   = (c == CH_DASH);
        n.phase = NP_SIGN;
      end else if (!is_blank) begin
        n.phase = NP_STOP;
      end
      return n;
    end
    if (!is_digit) begin
      n.phase = NP_STOP;
      return n;
    end
    n.phase = NP_DIGITS;
    grown = 36'(n.mag) * 36'd10 + 36'(c - CH_ZERO);
    if (grown > 36'(MAG_LIMIT)) begin
      n.mag  = MAG_LIMIT;
      n.over = 1'b1;
    end else begin
      n.mag = grown[31:0];
    end
    return n;
  endfunction

  // {saturated, value}
  function automatic logic [32:0] number_result(input number_acc_t n);
    if (n.neg) begin
      return n.over ? {1'b1, MAG_LIMIT} : {1'b0, -n.mag};
    end
    if (n.mag > POS_MAX) begin
      return {1'b1, POS_MAX};
    end
    return {1'b0, n.mag};
  endfunction

  task automatic parse_request_byte(input rlp_in_t item);
    logic [7:0]  c;
    logic        last;
    logic [2:0]  pos_before;
    req_type_t   cls;
    logic [32:0] start_res;
    logic [32:0] end_res;
    rlp_out_t    res;
    c          = item.byte_value;
    last       = item.final_byte;
    pos_before = char_pos;
    if (char_pos < 3) begin
      if (c != GET_WORD[23 - 8 * int'(char_pos) -: 8]) get_ok = 1'b0;
      if (c != INF_WORD[23 - 8 * int'(char_pos) -: 8]) inf_ok = 1'b0;
    end
    cls = get_ok ? REQ_GET : (inf_ok ? REQ_INF : REQ_BAD);

    // address runs from the fifth byte up to the first newline
    if (char_pos >= 4 && !addr_done && cls != REQ_BAD) begin
      if (c == CH_NL) begin
        addr_done = 1'b1;
      end else if (!last) begin
        if (addr_len < ADDR_MAX) begin
          res           = '0;
          res.kind      = KIND_ADDR;
          res.addr_byte = c;
          res.req_type  = cls;
          awaited_results.push_back(res);
          addr_len++;
        end else begin
          addr_over = 1'b1;
        end
      end
    end

    case (rng_phase)
      RP_SEEK: begin
        if (c == RANGE_WORD[47 - 8 * int'(kw_pos) -: 8]) begin
          kw_pos++;
        end else begin
          kw_pos = (c == RANGE_WORD[47:40]) ? 3'd1 : 3'd0;
        end
        if (kw_pos >= KEYWORD_LEN) rng_phase = RP_START;
      end
      RP_DASH: begin
        // the char right after a dash, unless a newline, goes to the end text as it is
        if (c == CH_NL) begin
          end_open  = 1'b1;
          rng_phase = RP_DONE;
        end else begin
          end_num   = feed_number(end_num, c);
          rng_phase = RP_END;
        end
      end
      RP_START, RP_END: begin
        if (c == CH_NL) begin
          rng_phase = RP_DONE;
        end else if (c == CH_DASH) begin
          rng_phase = RP_DASH;
        end else if (rng_phase == RP_START) begin
          start_num = feed_number(start_num, c);
        end else begin
          end_num = feed_number(end_num, c);
        end
      end
      default: ;
    endcase

    if (char_pos < 5) char_pos++;

    if (last) begin
      res                = '0;
      res.kind           = KIND_SUMMARY;
      res.req_type       = (pos_before >= 2) ? cls : REQ_BAD;
      res.addr_truncated = addr_over;
      res.end_open       = end_open;
      if (rng_phase != RP_SEEK) begin
        start_res            = number_result(start_num);
        end_res              = end_open ? {1'b0, 32'hFFFF_FFFF} : number_result(end_num);
        res.range_found      = 1'b1;
        res.range_start      = start_res[30:0];
        res.range_end        = end_res[31:0];
        res.number_saturated = start_res[32] | end_res[32];
      end
      awaited_results.push_back(res);
      clear_parse_state();
    end
  endtask

  task automatic compare_result(input rlp_out_t got);
    rlp_out_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("result %h with nothing expected", got));
      return;
    end
    want = awaited_results.pop_front();
    check_field("kind", got.kind, want.kind);
    check_field("addr_byte", got.addr_byte, want.addr_byte);
    check_field("req_type", got.req_type, want.req_type);
    check_field("addr_truncated", got.addr_truncated, want.addr_truncated);
    check_field("range_found", got.range_found, want.range_found);
    check_field("range_start", got.range_start, want.range_start);
    check_field("range_end", got.range_end, want.range_end);
    check_field("end_open", got.end_open, want.end_open);
    check_field("number_saturated", got.number_saturated, want.number_saturated);
  endtask

  // results first: a result at this edge always belongs to an earlier byte
  always @(posedge clk) begin
    if (rst) begin
      clear_parse_state();
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) compare_result(out_data);
      if (in_valid && in_ready) parse_request_byte(in_data);
    end
    pending_count <= awaited_results.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import rlp_pkg::*;

  localparam int TARGET_BYTES = 1350;
  localparam int QUIET_LIMIT  = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AFTER   = 400;

  typedef enum {RX_OPEN, RX_EVERY_FOURTH, RX_COIN, RX_SPARSE} rx_mode_t;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  rlp_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rlp_out_t out_data;
  int       mismatches;
  int       pending;

  logic [7:0] req_text[$];
  int         bytes_sent  = 0;
  int         burst_left  = 0;
  int         quiet_cycles = 0;

  rx_mode_t rx_mode     = RX_OPEN;
  int       rx_seg_left = 0;
  int       hold_left   = 0;
  logic     long_hold_done = 1'b0;

  always #4 clk = ~clk;

  request_line_parser_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  rlp_result_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      req_text.push_back(s[i]);
    end
  endtask

  task automatic add_number_text();
    string blanks;
    blanks = " \t\v\f\r";
    repeat ($urandom_range(0, 2)) req_text.push_back(blanks[$urandom_range(0, 4)]);
    case ($urandom_range(0, 3))
      0: add_text("+");
      1: add_text("-");
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: ;
      1: add_text("2147483647");
      2: add_text("2147483648");
      3: add_text("2147483649");
      4: repeat ($urandom_range(10, 13)) req_text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      default: repeat ($urandom_range(1, 4)) req_text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    endcase
    if ($urandom_range(0, 4) == 0) req_text.push_back(8'($urandom_range(33, 126)));
  endtask

  // mostly well formed requests with random content, some noise and cut-offs
  task automatic build_random_request();
    int    len;
    logic  dash_last;
    string letters;
    req_text.delete();
    dash_last = 1'b0;
    letters   = "GETINF";
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) req_text.push_back(8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(0, 5))
      0, 1: add_text("GET");
      2, 3: add_text("INF");
      4: repeat (3) req_text.push_back(letters[$urandom_range(0, 5)]);
      default: repeat (3) req_text.push_back(8'($urandom_range(0, 255)));
    endcase
    case ($urandom_range(0, 9))
      0: add_text("\n");
      1: req_text.push_back(8'($urandom_range(0, 255)));
      default: add_text(" ");
    endcase
    len = ($urandom_range(0, 14) == 0) ? $urandom_range(250, 262) : $urandom_range(0, 16);
    repeat (len) begin
      req_text.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
                                                       8'($urandom_range(33, 126)));
    end
    if ($urandom_range(0, 9) != 0) add_text("\n");
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(0, 6)) req_text.push_back(8'($urandom_range(33, 126)));
      add_text("\n");
    end
    if ($urandom_range(0, 3) != 0) begin
      // a broken keyword may start before the real one
      case ($urandom_range(0, 5))
        0: add_text("Rang");
        1: add_text("RRa");
        2: add_text("range ");
        default: ;
      endcase
      add_text("Range ");
      add_number_text();
      case ($urandom_range(0, 7))
        0: ;
        1: add_text("-\n");
        2: begin
          add_text("-");
          dash_last = 1'b1;
        end
        3: begin
          add_text("--");
          add_number_text();
        end
        4: begin
          add_text("-");
          add_number_text();
          add_text("-");
          add_number_text();
        end
        default: begin
          add_text("-");
          add_number_text();
        end
      endcase
    end
    if (!dash_last && $urandom_range(0, 1) == 1) begin
      add_text("\r\n");
      repeat ($urandom_range(0, 4)) req_text.push_back(8'($urandom_range(33, 126)));
    end
    if ($urandom_range(0, 5) == 0) begin
      len = $urandom_range(1, req_text.size());
      while (req_text.size() > len) void'(req_text.pop_back());
    end
  endtask

  task automatic send_byte(input logic [7:0] ch, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{byte_value: ch, final_byte: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic drive_request();
    for (int i = 0; i < req_text.size(); i++) begin
      send_byte(req_text[i], i == req_text.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    req_text.delete();
    add_text(s);
    drive_request();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // short requests, newline as fourth byte, zero and all-ones address bytes,
    // keyword at the very start with an open end on the final byte
    send_text("G");
    send_text("GE");
    send_text("GET");
    req_text.delete();
    add_text("INF\n");
    req_text.push_back(8'h00);
    req_text.push_back(8'hFF);
    add_text("\nZ");
    drive_request();
    send_text("Range 12-\n");

    while (bytes_sent < TARGET_BYTES) begin
      build_random_request();
      drive_request();
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // receiver: segments of its own pattern, plus one long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_ready  <= 1'b0;
    end else if (!long_hold_done && bytes_sent >= HOLD_AFTER) begin
      long_hold_done <= 1'b1;
      hold_left      <= LONG_HOLD - 1;
      out_ready      <= 1'b0;
    end else begin
      if (rx_seg_left == 0) begin
        rx_seg_left <= $urandom_range(5, 60);
        rx_mode     <= rx_mode_t'($urandom_range(0, 3));
      end else begin
        rx_seg_left <= rx_seg_left - 1;
      end
      case (rx_mode)
        RX_OPEN:         out_ready <= 1'b1;
        RX_EVERY_FOURTH: out_ready <= (rx_seg_left % 4) != 0;
        RX_COIN:         out_ready <= 1'($urandom_range(0, 1));
        default:         out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no transaction in %0d cycles", QUIET_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end
  end

endmodule

// ===== request_line_parser_unit.f =====
rtl/rlp_pkg.sv
rtl/rlp_num_acc.sv
rtl/rlp_addr_tracker.sv
rtl/rlp_range_scanner.sv
rtl/request_line_parser_unit.sv
rtl/rlp_checker.sv
verif/rlp_result_checker.sv
verif/tb_top.sv
